@@ sv/trie_longest_prefix_match_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros for the trie prefix match block.
// ----------------------------------------------------------------------------
`ifndef TRIE_LONGEST_PREFIX_MATCH_ASSERT_SVH
`define TRIE_LONGEST_PREFIX_MATCH_ASSERT_SVH

// same-cycle implication
`define TLPM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TLPM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/tlpm_pkg.sv @@
// ----------------------------------------------------------------------------
// tlpm_pkg
// Types and codes shared by the trie prefix match block and its checker.
// ----------------------------------------------------------------------------
package tlpm_pkg;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_QUERY  = 1'b1;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_POOL_FULL = 2'd1;
   localparam logic [1:0] STATUS_TOO_LONG  = 2'd2;

endpackage

@@ sv/tlpm_ram.sv @@
// ----------------------------------------------------------------------------
// tlpm_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tlpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/trie_longest_prefix_match.sv @@
// ----------------------------------------------------------------------------
// trie_longest_prefix_match
// Letter-serial dictionary trie with insert and longest-prefix query.
// ----------------------------------------------------------------------------
// Each node of the trie is one row of a single RAM holding, per letter, the
// child index and the end mark of that child. Each letter item is read and
// then evaluated: the accept cycle reads the row of the current node, and the
// EXEC state evaluates it and writes the row back when a child is added or
// marked. A last letter stays in EXEC while the previous result item is still
// untaken. After reset a clearing pass writes all NODE_COUNT rows, one
// per cycle, before the first item is accepted. Letters at or above
// ALPHABET_SIZE are treated as the last letter of the alphabet.
module trie_longest_prefix_match
   import tlpm_pkg::*;
#(
   parameter int NODE_COUNT    = 1024,
   parameter int ALPHABET_SIZE = 26,
   parameter int MAX_WORD_LEN  = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_type,
   input  logic [4:0] req_letter,
   input  logic       req_last_letter,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_result_kind,
   output logic [6:0] rsp_match_length,
   output logic [1:0] rsp_status
);

   localparam int NODE_W = $clog2(NODE_COUNT);
   localparam int CNT_W  = $clog2(NODE_COUNT + 1);
   localparam int LEN_W  = $clog2(MAX_WORD_LEN + 1);
   localparam int SYM_W  = $clog2(ALPHABET_SIZE);
   localparam int ENT_W  = NODE_W + 1;
   localparam int ROW_W  = ALPHABET_SIZE * ENT_W;

   state_type state_ff, state_in;

   logic [NODE_W-1:0] clr_cnt_ff, clr_cnt_in;

   logic [NODE_W-1:0] cursor_ff, cursor_in;
   logic [CNT_W-1:0]  used_ff, used_in;
   logic [LEN_W-1:0]  wlen_ff, wlen_in;
   logic [LEN_W-1:0]  best_ff, best_in;
   logic              dead_ff, dead_in;
   logic [1:0]        err_ff, err_in;

   logic              kind_ff;
   logic [SYM_W-1:0]  sym_ff, sym_in;
   logic              last_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_kind_ff;
   logic [6:0]        rsp_len_ff;
   logic [1:0]        rsp_status_ff;

   logic              accept;
   logic              exec_done;
   logic              walk_commit;
   logic              rsp_load;

   logic              ram_wr_en;
   logic [NODE_W-1:0] ram_wr_addr;
   logic [ROW_W-1:0]  ram_wr_data;
   logic [ROW_W-1:0]  row_rd;
   logic [ROW_W-1:0]  row_mod;

   logic [ENT_W-1:0]  entry;
   logic [ENT_W-1:0]  entry_new;
   logic [NODE_W-1:0] child;
   logic              alloc;
   logic              mark;
   logic              wr_need;
   logic [NODE_W-1:0] step_cursor;
   logic [CNT_W-1:0]  step_used;
   logic [LEN_W-1:0]  step_wlen;
   logic [LEN_W-1:0]  step_best;
   logic              step_dead;
   logic [1:0]        step_err;
   logic [LEN_W+6:0]  best_ext;

   tlpm_ram #(
      .WIDTH (ROW_W),
      .DEPTH (NODE_COUNT)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (cursor_ff),
      .rd_data (row_rd)
   );

   // letter saturation
   always_comb begin
      if (int'(req_letter) >= ALPHABET_SIZE) begin
         sym_in = SYM_W'(ALPHABET_SIZE - 1);
      end else begin
         sym_in = SYM_W'(req_letter);
      end
   end

   // one walk step on the row of the current node
   always_comb begin
      entry       = row_rd[int'(sym_ff) * ENT_W +: ENT_W];
      entry_new   = entry;
      child       = entry[NODE_W-1:0];
      alloc       = 1'b0;
      mark        = 1'b0;
      step_cursor = cursor_ff;
      step_used   = used_ff;
      step_wlen   = wlen_ff;
      step_best   = best_ff;
      step_dead   = dead_ff;
      step_err    = err_ff;
      if (kind_ff == KIND_INSERT) begin
         if (!dead_ff && err_ff == STATUS_OK) begin
            if (wlen_ff >= LEN_W'(MAX_WORD_LEN)) begin
               step_err = STATUS_TOO_LONG;
            end else if (child == '0 && used_ff >= CNT_W'(NODE_COUNT)) begin
               step_err = STATUS_POOL_FULL;
            end else begin
               if (child == '0) begin
                  child     = used_ff[NODE_W-1:0];
                  alloc     = 1'b1;
                  step_used = CNT_W'(used_ff + 1'b1);
               end
               step_cursor = child;
               step_wlen   = LEN_W'(wlen_ff + 1'b1);
               mark        = last_ff;
            end
         end
         entry_new = {entry[ENT_W-1] | mark, child};
      end else begin
         if (!dead_ff) begin
            if (child == '0) begin
               step_dead = 1'b1;
            end else begin
               step_cursor = child;
               step_wlen   = LEN_W'(wlen_ff + 1'b1);
               if (entry[ENT_W-1]) begin
                  step_best = LEN_W'(wlen_ff + 1'b1);
               end
            end
         end
      end
      wr_need = alloc | mark;
      for (int i = 0; i < ALPHABET_SIZE; i++) begin
         if (SYM_W'(i) == sym_ff) begin
            row_mod[i*ENT_W +: ENT_W] = entry_new;
         end else begin
            row_mod[i*ENT_W +: ENT_W] = row_rd[i*ENT_W +: ENT_W];
         end
      end
   end

   // walk state, cleared after every last letter
   always_comb begin
      used_in = step_used;
      if (last_ff) begin
         cursor_in = '0;
         wlen_in   = '0;
         best_in   = '0;
         dead_in   = 1'b0;
         err_in    = STATUS_OK;
      end else begin
         cursor_in = step_cursor;
         wlen_in   = step_wlen;
         best_in   = step_best;
         dead_in   = step_dead;
         err_in    = step_err;
      end
   end

   assign exec_done = !last_ff || !rsp_valid_ff || rsp_ready;
   assign best_ext  = {7'd0, step_best};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == NODE_W'(NODE_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // outputs of the state machine
   always_comb begin
      req_ready   = 1'b0;
      walk_commit = 1'b0;
      rsp_load    = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = cursor_ff;
      ram_wr_data = row_mod;
      clr_cnt_in  = clr_cnt_ff;
      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_cnt_ff;
            ram_wr_data = '0;
            clr_cnt_in  = NODE_W'(clr_cnt_ff + 1'b1);
         end
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_EXEC: begin
            walk_commit = exec_done;
            rsp_load    = exec_done && last_ff;
            ram_wr_en   = exec_done && wr_need;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign accept       = req_valid && req_ready;
   assign rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         cursor_ff    <= '0;
         used_ff      <= CNT_W'(1);
         wlen_ff      <= '0;
         best_ff      <= '0;
         dead_ff      <= 1'b0;
         err_ff       <= STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (walk_commit) begin
            cursor_ff <= cursor_in;
            used_ff   <= used_in;
            wlen_ff   <= wlen_in;
            best_ff   <= best_in;
            dead_ff   <= dead_in;
            err_ff    <= err_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_type;
         sym_ff  <= sym_in;
         last_ff <= req_last_letter;
      end
      if (rsp_load) begin
         rsp_kind_ff <= kind_ff;
         if (kind_ff == KIND_QUERY) begin
            rsp_len_ff    <= best_ext[6:0];
            rsp_status_ff <= STATUS_OK;
         end else begin
            rsp_len_ff    <= 7'd0;
            rsp_status_ff <= step_err;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = rsp_kind_ff;
   assign rsp_match_length = rsp_len_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

@@ sv/tlpm_checker.sv @@
// ----------------------------------------------------------------------------
// tlpm_checker
// Port-level assertions for the trie prefix match block, bound to the top.
// ----------------------------------------------------------------------------
`include "trie_longest_prefix_match_assert.svh"

module tlpm_checker
   import tlpm_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_type,
   input logic [4:0] req_letter,
   input logic       req_last_letter,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_result_kind,
   input logic [6:0] rsp_match_length,
   input logic [1:0] rsp_status
);

   `TLPM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result_kind) && $stable(rsp_match_length) && $stable(rsp_status), "result item changed while stalled")

   `TLPM_ASSERT_NEXT(a_req_gap, clock, reset, req_valid && req_ready, !req_ready, "letter accepted in back-to-back cycles")

   `TLPM_ASSERT_NOW(a_query_ok, clock, reset, rsp_valid && rsp_result_kind == KIND_QUERY, rsp_status == STATUS_OK, "query result with error status")

   `TLPM_ASSERT_NOW(a_insert_len, clock, reset, rsp_valid && rsp_result_kind == KIND_INSERT, rsp_match_length == 7'd0, "insert result with nonzero length")

endmodule

bind trie_longest_prefix_match tlpm_checker u_tlpm_checker (.*);

@@ verif/trie_longest_prefix_match_test.sv @@
// ----------------------------------------------------------------------------
// trie_longest_prefix_match_test
// Self-checking bench for the letter-serial trie with longest-prefix query.
// ----------------------------------------------------------------------------
// A mirror of the trie tracks the node pool, the end marks and the walk state
// from every accepted letter and queues the result expected on each last
// letter. Results are compared field by field in order. Stimulus starts with
// a short directed set, then runs random words (dictionary inserts, queries
// replayed from earlier inserts, fresh queries, mixed and over-long words)
// under several idle and stall mixes, then fills the node pool and keeps
// going on a full pool.
// ----------------------------------------------------------------------------
module trie_longest_prefix_match_test;
   timeunit 1ns;
   timeprecision 1ps;
   import tlpm_pkg::*;

   localparam int NODE_COUNT    = 1024;
   localparam int ALPHABET_SIZE = 26;
   localparam int MAX_WORD_LEN  = 64;
   localparam int BANK_DEPTH    = 64;
   localparam int BANK_WIDTH    = 16;

   typedef struct packed {
      logic       kind;
      logic [6:0] len;
      logic [1:0] status;
   } trie_result_type;

   class trie_mirror;
      bit [9:0]        links [NODE_COUNT*ALPHABET_SIZE];
      bit              marks [NODE_COUNT];
      int unsigned     nodes_used = 1;
      int unsigned     cursor;
      int unsigned     word_len;
      int unsigned     best;
      bit              dead;
      logic [1:0]      err = STATUS_OK;
      trie_result_type awaited [$];
      int              errors;

      task flag_mismatch(string msg);
         if (errors < 40) $display("%0t ns mismatch: %s", $time, msg);
         errors++;
      endtask

      function void take_letter(logic kind, logic [4:0] sym_in, logic last);
         int unsigned     sym;
         int unsigned     slot;
         int unsigned     next;
         trie_result_type r;
         sym  = (sym_in >= ALPHABET_SIZE) ? ALPHABET_SIZE - 1 : sym_in;
         slot = cursor * ALPHABET_SIZE + sym;
         if (kind == KIND_INSERT) begin
            if (!dead && err == STATUS_OK) begin
               if (word_len >= MAX_WORD_LEN) begin
                  err = STATUS_TOO_LONG;
               end else begin
                  next = links[slot];
                  if (next == 0) begin
                     if (nodes_used >= NODE_COUNT) begin
                        err = STATUS_POOL_FULL;
                     end else begin
                        next = nodes_used;
                        nodes_used++;
                        links[slot] = 10'(next);
                     end
                  end
                  if (err == STATUS_OK) begin
                     cursor = next;
                     word_len++;
                  end
               end
            end
         end else if (!dead) begin
            next = links[slot];
            if (next == 0) begin
               dead = 1'b1;
            end else begin
               cursor = next;
               word_len++;
               if (marks[next]) best = word_len;
            end
         end
         if (last) begin
            r.kind = kind;
            if (kind == KIND_INSERT) begin
               if (!dead && err == STATUS_OK) marks[cursor] = 1'b1;
               r.len    = '0;
               r.status = err;
            end else begin
               r.len    = 7'(best);
               r.status = STATUS_OK;
            end
            awaited.push_back(r);
            cursor   = 0;
            word_len = 0;
            best     = 0;
            dead     = 1'b0;
            err      = STATUS_OK;
         end
      endfunction

      task check_result(logic kind, logic [6:0] len, logic [1:0] status);
         trie_result_type want;
         if (awaited.size() == 0) begin
            flag_mismatch("result item with no word pending");
            return;
         end
         want = awaited.pop_front();
         if (kind !== want.kind)
            flag_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
         if (len !== want.len)
            flag_mismatch($sformatf("match_length %0d, expected %0d", len, want.len));
         if (status !== want.status)
            flag_mismatch($sformatf("status %0d, expected %0d", status, want.status));
      endtask
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_type = KIND_INSERT;
   logic [4:0] req_letter = '0;
   logic       req_last_letter = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_result_kind;
   logic [6:0] rsp_match_length;
   logic [1:0] rsp_status;

   trie_mirror tracker = new();
   int         send_idle_pct = 0;
   int         stall_pct = 0;
   int         items_sent = 0;

   logic [4:0] word_sym  [0:79];
   logic       word_kind [0:79];
   int         word_len;
   logic [4:0] bank [0:BANK_DEPTH-1][0:BANK_WIDTH-1];
   int         bank_len [0:BANK_DEPTH-1];
   int         bank_count = 0;
   int         bank_next = 0;

   trie_longest_prefix_match #(
      .NODE_COUNT   (NODE_COUNT),
      .ALPHABET_SIZE(ALPHABET_SIZE),
      .MAX_WORD_LEN (MAX_WORD_LEN)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_letter      (req_letter),
      .req_last_letter (req_last_letter),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_kind (rsp_result_kind),
      .rsp_match_length(rsp_match_length),
      .rsp_status      (rsp_status)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.check_result(rsp_result_kind, rsp_match_length, rsp_status);
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   task send_letter(input logic kind, input logic [4:0] sym, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_letter      <= sym;
      req_last_letter <= last;
      do @(posedge clock); while (!req_ready);
      tracker.take_letter(kind, sym, last);
      items_sent++;
   endtask

   task send_word();
      for (int i = 0; i < word_len; i++)
         send_letter(word_kind[i], word_sym[i], i == word_len - 1);
   endtask

   task drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.awaited.size() != 0) @(posedge clock);
   endtask

   function logic [4:0] pick_letter();
      int r;
      r = $urandom_range(99);
      if (r < 70) return 5'($urandom_range(3));
      else if (r < 95) return 5'($urandom_range(25));
      else return 5'($urandom_range(31, 26));
   endfunction

   task random_word();
      int         r;
      int         b;
      logic [4:0] fixed;
      r = $urandom_range(99);
      if (r < 38) begin
         word_len = $urandom_range(8, 1);
         for (int i = 0; i < word_len; i++) begin
            word_sym[i]  = pick_letter();
            word_kind[i] = KIND_INSERT;
            bank[bank_next][i] = word_sym[i];
         end
         bank_len[bank_next] = word_len;
         bank_next = (bank_next + 1) % BANK_DEPTH;
         if (bank_count < BANK_DEPTH) bank_count++;
      end else if (r < 72 && bank_count > 0) begin
         b = $urandom_range(bank_count - 1);
         word_len = bank_len[b];
         for (int i = 0; i < word_len; i++) word_sym[i] = bank[b][i];
         case ($urandom_range(2))
            0: ;
            1: word_len = $urandom_range(word_len, 1);
            default: begin
               repeat ($urandom_range(3, 1)) begin
                  word_sym[word_len] = pick_letter();
                  word_len++;
               end
            end
         endcase
         for (int i = 0; i < word_len; i++) word_kind[i] = KIND_QUERY;
      end else if (r < 88) begin
         word_len = $urandom_range(8, 1);
         for (int i = 0; i < word_len; i++) begin
            word_sym[i]  = pick_letter();
            word_kind[i] = KIND_QUERY;
         end
      end else if (r < 97) begin
         word_len = $urandom_range(8, 2);
         for (int i = 0; i < word_len; i++) begin
            word_sym[i]  = pick_letter();
            word_kind[i] = $urandom_range(1) ? KIND_QUERY : KIND_INSERT;
         end
      end else begin
         word_len = $urandom_range(70, 60);
         fixed = pick_letter();
         for (int i = 0; i < word_len; i++) begin
            word_sym[i]  = $urandom_range(3) == 0 ? pick_letter() : fixed;
            word_kind[i] = KIND_INSERT;
         end
      end
      send_word();
   endtask

   task run_phase(input int idle, input int stall, input int count);
      int target;
      send_idle_pct = idle;
      stall_pct     = stall;
      target        = items_sent + count;
      while (items_sent < target) random_word();
      drain();
   endtask

   task fill_word();
      word_len = 30;
      for (int i = 0; i < word_len; i++) begin
         word_sym[i]  = 5'($urandom_range(25));
         word_kind[i] = KIND_INSERT;
      end
      send_word();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: empty trie, extreme and saturated letters, mixed word
      send_letter(KIND_QUERY,  5'd0,  1'b1);
      send_letter(KIND_INSERT, 5'd0,  1'b1);
      send_letter(KIND_INSERT, 5'd25, 1'b1);
      send_letter(KIND_INSERT, 5'd25, 1'b0);
      send_letter(KIND_INSERT, 5'd31, 1'b1);
      send_letter(KIND_QUERY,  5'd25, 1'b0);
      send_letter(KIND_QUERY,  5'd31, 1'b0);
      send_letter(KIND_QUERY,  5'd30, 1'b1);
      send_letter(KIND_QUERY,  5'd0,  1'b0);
      send_letter(KIND_QUERY,  5'd1,  1'b1);
      send_letter(KIND_INSERT, 5'd2,  1'b0);
      send_letter(KIND_QUERY,  5'd2,  1'b1);
      send_letter(KIND_QUERY,  5'd0,  1'b1);
      send_letter(KIND_INSERT, 5'd0,  1'b0);
      send_letter(KIND_INSERT, 5'd1,  1'b0);
      send_letter(KIND_INSERT, 5'd2,  1'b1);
      send_letter(KIND_QUERY,  5'd0,  1'b0);
      send_letter(KIND_QUERY,  5'd1,  1'b0);
      send_letter(KIND_QUERY,  5'd2,  1'b0);
      send_letter(KIND_QUERY,  5'd3,  1'b1);
      drain();

      // one word past the length limit along a single-letter chain
      word_len = 70;
      for (int i = 0; i < word_len; i++) begin
         word_sym[i]  = 5'd16;
         word_kind[i] = KIND_INSERT;
      end
      send_word();

      run_phase(0, 0, 300);
      run_phase(82, 0, 300);
      run_phase(0, 82, 300);
      run_phase(15, 15, 300);

      send_idle_pct = 0;
      stall_pct     = 0;
      while (tracker.nodes_used < NODE_COUNT) fill_word();
      repeat (4) fill_word();
      drain();
      run_phase(15, 15, 200);

      repeat (16) @(posedge clock);
      if (tracker.awaited.size() != 0)
         tracker.flag_mismatch($sformatf("%0d results never arrived",
                                         tracker.awaited.size()));
      if (tracker.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #6ms;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+sv
sv/tlpm_pkg.sv
sv/tlpm_ram.sv
sv/trie_longest_prefix_match.sv
sv/tlpm_checker.sv
verif/trie_longest_prefix_match_test.sv
